/* hdl/cti_pkg.sv */
// Shared types, widths and helpers for the cubic trajectory interpolator.
// No dependencies; compile first.
package cti_pkg;

  // Internal widths, from bounds on Q16.16 operands
  localparam int C2_MAG_W = 50;  // |c2| < 2^50
  localparam int C3_MAG_W = 49;  // |c3| < 2^49
  localparam int SPLIT_W  = 25;  // low part of a split multiplicand
  localparam int VT_W     = 48;  // v0*tau/2^16, signed
  localparam int SUM_W    = 53;  // wide signed sums ahead of saturation
  localparam int S_QW     = 32;  // quotient bits of the segment fraction
  localparam int V_QW     = 34;  // quotient bits of the velocity scale

  typedef enum logic {
    REG_START_TIME = 1'b0,
    REG_GOAL_TIME  = 1'b1
  } cti_reg_t;

  typedef struct packed {
    logic        [31:0] now_time;
    logic signed [31:0] start_position;
    logic signed [31:0] start_velocity;
    logic signed [31:0] goal_position;
    logic signed [31:0] goal_velocity;
  } cti_in_t;

  typedef struct packed {
    logic signed [31:0] position_out;
    logic signed [31:0] velocity_out;
    logic               reached_goal;
  } cti_out_t;

  // Context carried through the fraction divider
  typedef struct packed {
    logic                  pre_start;
    logic                  after;
    logic signed [31:0]    x0;
    logic signed [31:0]    v0;
    logic signed [31:0]    x1;
    logic signed [31:0]    v1;
    logic signed [VT_W-1:0] vt;
    logic                  c2_neg;
    logic [C2_MAG_W-1:0]   c2_mag;
    logic                  c3_neg;
    logic [C3_MAG_W-1:0]   c3_mag;
  } cti_ctx_t;

  // Context carried through the velocity divider
  typedef struct packed {
    logic               pre_start;
    logic               after;
    logic signed [31:0] v0;
    logic signed [31:0] v1;
    logic signed [31:0] pos;
    logic               n_neg;
    logic               ovf;
  } cti_ctx2_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > SUM_W'(64'sd2147483647)) begin
      r = 32'sh7fffffff;
    end else if (v < -SUM_W'(64'sd2147483648)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/cti_chan_if.sv */
// Valid/ready channel carrying one payload word.
// Payload type is a parameter; types come from cti_pkg.
interface cti_chan_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/cubic_trajectory_interpolator_top.sv */
// Top level of the one-axis cubic Hermite trajectory interpolator.
// Depends on cti_pkg, cti_chan_if and cti_divpipe.

// Takes one word per clock while in_ch.ready is high and returns one result
// word per input word, in order. The pipeline holds two restoring dividers
// that resolve one quotient bit per stage (32 stages for the segment
// fraction, 34 for the velocity scale) plus eight arithmetic stages and the
// output register. Any number of words may be in flight; when the output
// stalls, the pipeline keeps moving until a word reaches its last stage.
// Segment start and goal times are written through the cfg port and must
// only change while no word is in flight.
module cubic_trajectory_interpolator_top (
  input  logic              clk,
  input  logic              rst_n,
  cti_chan_if.sink          in_ch,
  cti_chan_if.source        out_ch,
  input  logic              cfg_we,
  input  cti_pkg::cti_reg_t cfg_index,
  input  logic [31:0]       cfg_wdata
);
  import cti_pkg::*;

  // Configuration
  logic [31:0] start_r, goal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      goal_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_TIME: start_r <= cfg_wdata;
        REG_GOAL_TIME:  goal_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [31:0] seg_t;
  assign seg_t = goal_r - start_r;

  // Flow control
  logic     adv;
  logic     d2_v;
  logic     out_valid_r;
  cti_out_t out_data_r;

  assign adv         = !(d2_v && out_valid_r && !out_ch.ready);
  assign in_ch.ready = adv;

  // Stage 1: flags and operand sums
  logic               s1_v_r, s1_before_r, s1_after_r;
  logic signed [31:0] s1_x0_r, s1_v0_r, s1_x1_r, s1_v1_r;
  logic [31:0]        s1_tau_r;
  logic signed [33:0] s1_a2_r;
  logic signed [32:0] s1_a3_r, s1_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_before_r <= (in_ch.data.now_time <= start_r);
      s1_after_r  <= (in_ch.data.now_time >= goal_r);
      s1_x0_r     <= in_ch.data.start_position;
      s1_v0_r     <= in_ch.data.start_velocity;
      s1_x1_r     <= in_ch.data.goal_position;
      s1_v1_r     <= in_ch.data.goal_velocity;
      s1_tau_r    <= in_ch.data.now_time - start_r;
      s1_a2_r     <= (34'(in_ch.data.start_velocity) <<< 1) + 34'(in_ch.data.goal_velocity);
      s1_a3_r     <= 33'(in_ch.data.start_velocity) + 33'(in_ch.data.goal_velocity);
      s1_d_r      <= 33'(in_ch.data.goal_position) - 33'(in_ch.data.start_position);
    end
  end

  // Stage 2: products with tau and the segment length
  logic [31:0] v0_mag;
  logic [32:0] a2_mag, a3_mag;
  logic [63:0] vt_p;
  logic [64:0] p2_p, p3_p;

  assign v0_mag = s1_v0_r[31] ? 32'(-s1_v0_r) : 32'(s1_v0_r);
  assign a2_mag = s1_a2_r[33] ? 33'(-s1_a2_r) : 33'(s1_a2_r);
  assign a3_mag = s1_a3_r[32] ? 33'(-s1_a3_r) : 33'(s1_a3_r);
  assign vt_p   = 64'(v0_mag) * 64'(s1_tau_r);
  assign p2_p   = 65'(a2_mag) * 65'(seg_t);
  assign p3_p   = 65'(a3_mag) * 65'(seg_t);

  logic               s2_v_r, s2_before_r, s2_after_r;
  logic signed [31:0] s2_x0_r, s2_v0_r, s2_x1_r, s2_v1_r;
  logic [31:0]        s2_tau_r;
  logic signed [32:0] s2_d_r;
  logic               s2_vn_r, s2_a2n_r, s2_a3n_r;
  logic [63:0]        s2_vt_r;
  logic [64:0]        s2_p2_r, s2_p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_before_r <= s1_before_r;
      s2_after_r  <= s1_after_r;
      s2_x0_r     <= s1_x0_r;
      s2_v0_r     <= s1_v0_r;
      s2_x1_r     <= s1_x1_r;
      s2_v1_r     <= s1_v1_r;
      s2_tau_r    <= s1_tau_r;
      s2_d_r      <= s1_d_r;
      s2_vn_r     <= s1_v0_r[31];
      s2_a2n_r    <= s1_a2_r[33];
      s2_a3n_r    <= s1_a3_r[32];
      s2_vt_r     <= vt_p;
      s2_p2_r     <= p2_p;
      s2_p3_r     <= p3_p;
    end
  end

  // Stage 3: polynomial coefficients as sign and magnitude
  logic signed [VT_W-1:0] vt_c;
  logic signed [50:0]     sq2, c2_c;
  logic signed [49:0]     sq3, c3_c;
  cti_ctx_t               ctx_c;

  assign vt_c = s2_vn_r ? -$signed(s2_vt_r[63:16]) : $signed(s2_vt_r[63:16]);
  assign sq2  = s2_a2n_r ? -$signed({2'b00, s2_p2_r[64:16]})
                         :  $signed({2'b00, s2_p2_r[64:16]});
  assign sq3  = s2_a3n_r ? -$signed({1'b0, s2_p3_r[64:16]})
                         :  $signed({1'b0, s2_p3_r[64:16]});
  assign c2_c = (51'(s2_d_r) <<< 1) + 51'(s2_d_r) - sq2;
  assign c3_c = sq3 - (50'(s2_d_r) <<< 1);

  always_comb begin
    ctx_c.pre_start = s2_before_r;
    ctx_c.after     = s2_after_r;
    ctx_c.x0        = s2_x0_r;
    ctx_c.v0        = s2_v0_r;
    ctx_c.x1        = s2_x1_r;
    ctx_c.v1        = s2_v1_r;
    ctx_c.vt        = vt_c;
    ctx_c.c2_neg    = c2_c[50];
    ctx_c.c2_mag    = c2_c[50] ? C2_MAG_W'(-c2_c) : C2_MAG_W'(c2_c);
    ctx_c.c3_neg    = c3_c[49];
    ctx_c.c3_mag    = c3_c[49] ? C3_MAG_W'(-c3_c) : C3_MAG_W'(c3_c);
  end

  logic        s3_v_r;
  logic [31:0] s3_tau_r;
  cti_ctx_t    s3_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tau_r <= s2_tau_r;
      s3_ctx_r <= ctx_c;
    end
  end

  // Segment fraction s = tau * 2^32 / T
  logic            d1_v;
  logic [S_QW-1:0] d1_s;
  cti_ctx_t        d1_ctx;

  cti_divpipe #(
    .QW (S_QW),
    .DW (32),
    .SW ($bits(cti_ctx_t))
  ) u_div_frac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s3_v_r),
    .in_rem    (s3_tau_r),
    .in_low    ('0),
    .divisor   (seg_t),
    .in_side   (s3_ctx_r),
    .out_valid (d1_v),
    .out_quo   (d1_s),
    .out_side  (d1_ctx)
  );

  // Stage 4: s^2 and c2*s
  logic [SPLIT_W-1:0] d1_c2h, d1_c2l;
  assign d1_c2h = d1_ctx.c2_mag[C2_MAG_W-1:SPLIT_W];
  assign d1_c2l = d1_ctx.c2_mag[SPLIT_W-1:0];

  logic        s4_v_r;
  logic [31:0] s4_s_r;
  logic [63:0] s4_sq_r;
  logic [56:0] s4_c2sh_r, s4_c2sl_r;
  cti_ctx_t    s4_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= d1_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_s_r    <= d1_s;
      s4_sq_r   <= 64'(d1_s) * 64'(d1_s);
      s4_c2sh_r <= 57'(d1_c2h) * 57'(d1_s);
      s4_c2sl_r <= 57'(d1_c2l) * 57'(d1_s);
      s4_ctx_r  <= d1_ctx;
    end
  end

  // Stage 5: s^3, c2*s2, c3*s2 and the first velocity term
  logic [31:0]        s2_frac;
  logic [81:0]        c2s_full;
  logic [50:0]        n1_mag;
  logic signed [51:0] tn1_c;

  assign s2_frac  = s4_sq_r[63:32];
  assign c2s_full = (82'(s4_c2sh_r) << SPLIT_W) + 82'(s4_c2sl_r);
  assign n1_mag   = c2s_full[81:31];
  assign tn1_c    = s4_ctx_r.c2_neg ? -$signed({1'b0, n1_mag}) : $signed({1'b0, n1_mag});

  logic               s5_v_r;
  logic [63:0]        s5_s3f_r;
  logic [56:0]        s5_c2s2h_r, s5_c2s2l_r, s5_c3s2l_r;
  logic [55:0]        s5_c3s2h_r;
  logic signed [51:0] s5_tn1_r;
  cti_ctx_t           s5_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= s4_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_s3f_r   <= 64'(s2_frac) * 64'(s4_s_r);
      s5_c2s2h_r <= 57'(s4_ctx_r.c2_mag[C2_MAG_W-1:SPLIT_W]) * 57'(s2_frac);
      s5_c2s2l_r <= 57'(s4_ctx_r.c2_mag[SPLIT_W-1:0]) * 57'(s2_frac);
      s5_c3s2h_r <= 56'(s4_ctx_r.c3_mag[C3_MAG_W-1:SPLIT_W]) * 56'(s2_frac);
      s5_c3s2l_r <= 57'(s4_ctx_r.c3_mag[SPLIT_W-1:0]) * 57'(s2_frac);
      s5_tn1_r   <= tn1_c;
      s5_ctx_r   <= s4_ctx_r;
    end
  end

  // Stage 6: c3*s3, position term of c2, velocity term of c3
  logic [31:0]        s3_frac;
  logic [81:0]        c2s2_full;
  logic [80:0]        c3s2_full;
  logic [82:0]        c3s2_x3;
  logic signed [50:0] tp2_c;
  logic signed [51:0] tn2_c;

  assign s3_frac   = s5_s3f_r[63:32];
  assign c2s2_full = (82'(s5_c2s2h_r) << SPLIT_W) + 82'(s5_c2s2l_r);
  assign c3s2_full = (81'(s5_c3s2h_r) << SPLIT_W) + 81'(s5_c3s2l_r);
  assign c3s2_x3   = (83'(c3s2_full) << 1) + 83'(c3s2_full);
  assign tp2_c     = s5_ctx_r.c2_neg ? -$signed({1'b0, c2s2_full[81:32]})
                                     :  $signed({1'b0, c2s2_full[81:32]});
  assign tn2_c     = s5_ctx_r.c3_neg ? -$signed({1'b0, c3s2_x3[82:32]})
                                     :  $signed({1'b0, c3s2_x3[82:32]});

  logic               s6_v_r;
  logic [55:0]        s6_c3s3h_r;
  logic [56:0]        s6_c3s3l_r;
  logic signed [50:0] s6_tp2_r;
  logic signed [51:0] s6_tn1_r, s6_tn2_r;
  cti_ctx_t           s6_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else if (adv) s6_v_r <= s5_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_c3s3h_r <= 56'(s5_ctx_r.c3_mag[C3_MAG_W-1:SPLIT_W]) * 56'(s3_frac);
      s6_c3s3l_r <= 57'(s5_ctx_r.c3_mag[SPLIT_W-1:0]) * 57'(s3_frac);
      s6_tp2_r   <= tp2_c;
      s6_tn1_r   <= s5_tn1_r;
      s6_tn2_r   <= tn2_c;
      s6_ctx_r   <= s5_ctx_r;
    end
  end

  // Stage 7: position and velocity numerator sums
  logic [80:0]        c3s3_full;
  logic signed [49:0] tp3_c;

  assign c3s3_full = (81'(s6_c3s3h_r) << SPLIT_W) + 81'(s6_c3s3l_r);
  assign tp3_c     = s6_ctx_r.c3_neg ? -$signed({1'b0, c3s3_full[80:32]})
                                     :  $signed({1'b0, c3s3_full[80:32]});

  logic                    s7_v_r;
  logic signed [SUM_W-1:0] s7_pos_r, s7_n_r;
  cti_ctx_t                s7_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else if (adv) s7_v_r <= s6_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_pos_r <= SUM_W'(s6_ctx_r.x0) + SUM_W'(s6_ctx_r.vt) + SUM_W'(s6_tp2_r) + SUM_W'(tp3_c);
      s7_n_r   <= SUM_W'(s6_tn1_r) + SUM_W'(s6_tn2_r);
      s7_ctx_r <= s6_ctx_r;
    end
  end

  // Stage 8: select position, set up the velocity division
  logic [51:0] m_mag;
  logic [33:0] m_hi;
  cti_ctx2_t   ctx2_c;

  assign m_mag = s7_n_r[SUM_W-1] ? 52'(-s7_n_r) : 52'(s7_n_r);
  assign m_hi  = m_mag[51:18];

  always_comb begin
    ctx2_c.pre_start = s7_ctx_r.pre_start;
    ctx2_c.after     = s7_ctx_r.after;
    ctx2_c.v0        = s7_ctx_r.v0;
    ctx2_c.v1        = s7_ctx_r.v1;
    ctx2_c.n_neg     = s7_n_r[SUM_W-1];
    // quotient would not fit: clamp, the result saturates anyway
    ctx2_c.ovf       = (m_hi >= 34'(seg_t));
    if (s7_ctx_r.pre_start) begin
      ctx2_c.pos = s7_ctx_r.x0;
    end else if (s7_ctx_r.after) begin
      ctx2_c.pos = s7_ctx_r.x1;
    end else begin
      ctx2_c.pos = sat32(s7_pos_r);
    end
  end

  logic            s8_v_r;
  logic [31:0]     s8_rem_r;
  logic [V_QW-1:0] s8_low_r;
  cti_ctx2_t       s8_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s8_v_r <= 1'b0;
    else if (adv) s8_v_r <= s7_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_rem_r <= m_hi[31:0];
      s8_low_r <= {m_mag[17:0], 16'h0000};
      s8_ctx_r <= ctx2_c;
    end
  end

  // Velocity scale n * 2^16 / T
  logic [V_QW-1:0] d2_q;
  cti_ctx2_t       d2_ctx;

  cti_divpipe #(
    .QW (V_QW),
    .DW (32),
    .SW ($bits(cti_ctx2_t))
  ) u_div_vel (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s8_v_r),
    .in_rem    (s8_rem_r),
    .in_low    (s8_low_r),
    .divisor   (seg_t),
    .in_side   (s8_ctx_r),
    .out_valid (d2_v),
    .out_quo   (d2_q),
    .out_side  (d2_ctx)
  );

  // Final velocity and output register
  logic [V_QW:0]      vmag;
  logic signed [36:0] vel_w;
  cti_out_t           out_c;

  assign vmag  = d2_ctx.ovf ? ((V_QW+1)'(1) << V_QW) : {1'b0, d2_q};
  assign vel_w = 37'(d2_ctx.v0) + (d2_ctx.n_neg ? -$signed({1'b0, vmag})
                                                :  $signed({1'b0, vmag}));

  always_comb begin
    out_c.position_out = d2_ctx.pos;
    out_c.reached_goal = d2_ctx.after;
    if (d2_ctx.pre_start) begin
      out_c.velocity_out = d2_ctx.v0;
    end else if (d2_ctx.after) begin
      out_c.velocity_out = d2_ctx.v1;
    end else begin
      out_c.velocity_out = sat32(SUM_W'(vel_w));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_data_r <= out_c;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

/* hdl/cti_divpipe.sv */
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on nothing but its parameters; used by the top level.
module cti_divpipe #(
  parameter int QW = 32,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [QW-1:0] v_r;
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];

  logic [DW-1:0] si_rem  [QW];
  logic [QW-1:0] si_low  [QW];
  logic [QW-1:0] si_quo  [QW];
  logic [SW-1:0] si_side [QW];

  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] low_nxt [QW];
  logic [QW-1:0] quo_nxt [QW];

  assign si_rem[0]  = in_rem;
  assign si_low[0]  = in_low;
  assign si_quo[0]  = '0;
  assign si_side[0] = in_side;

  for (genvar k = 1; k < QW; k++) begin : g_link
    assign si_rem[k]  = rem_r[k-1];
    assign si_low[k]  = low_r[k-1];
    assign si_quo[k]  = quo_r[k-1];
    assign si_side[k] = side_r[k-1];
  end

  always_comb begin
    logic [DW:0] r2;
    logic        ge;
    for (int k = 0; k < QW; k++) begin
      r2 = {si_rem[k], si_low[k][QW-1]};
      ge = (r2 >= {1'b0, divisor});
      rem_nxt[k] = ge ? DW'(r2 - {1'b0, divisor}) : r2[DW-1:0];
      low_nxt[k] = si_low[k] << 1;
      quo_nxt[k] = {si_quo[k][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= rem_nxt;
      low_r  <= low_nxt;
      quo_r  <= quo_nxt;
      side_r <= si_side;
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

/* hdl/cti_checker.sv */
// Port-level checks for the cubic trajectory interpolator, bound to its top.
// Depends on cti_pkg and the top level.
module cti_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input cti_pkg::cti_out_t out_data
);
  import cti_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input side only stalls behind a blocked output word
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output is free");

  // A blocked output with a free input means the pipe still has room
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && in_valid && in_ready |=> out_valid)
    else $error("result word lost while input accepted");

endmodule

bind cubic_trajectory_interpolator_top cti_checker u_cti_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

/* tb/sv/cubic_trajectory_interpolator_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for the cubic trajectory interpolator top level.
// Depends on cti_pkg, cti_chan_if and the RTL top; predicts each result in Q16.16.
module cubic_trajectory_interpolator_top_tb;
  import cti_pkg::*;

  localparam int LIMIT_CYCLES = 600000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cti_reg_t cfg_index;
  logic [31:0] cfg_wdata;

  cti_chan_if #(.data_t(cti_in_t))  in_ch();
  cti_chan_if #(.data_t(cti_out_t)) out_ch();

  cubic_trajectory_interpolator_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  cti_in_t  pending_words[$];
  cti_out_t expected_axis[$];
  logic [31:0] seg_start_q;
  logic [31:0] seg_goal_q;
  bit          burst_mode;
  int          mismatches;
  int          words_in;
  int          send_gap;
  int          recv_gap;
  int          hold_left;
  bit          hold_done;
  int          cycle_count;

  // trunc(a * b / 2^k), rounding toward zero
  function automatic longint mul_shift(longint a, logic [63:0] b, int k);
    logic         neg;
    logic [63:0]  m;
    logic [127:0] p;
    neg = a < 0;
    m = neg ? 64'(-a) : 64'(a);
    p = {64'b0, m} * {64'b0, b};
    p = p >> k;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic logic [31:0] sat_q16(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic cti_out_t interpolate_axis(cti_in_t w, logic [31:0] t0, logic [31:0] t1);
    longint x0, v0, x1, v1, pos, vel, d, c2, c3, n;
    logic [63:0] span, tau, s, s2, s3, m, q, r, mag;
    cti_out_t res;
    x0 = longint'(w.start_position);
    v0 = longint'(w.start_velocity);
    x1 = longint'(w.goal_position);
    v1 = longint'(w.goal_velocity);
    if (w.now_time <= t0) begin
      pos = x0;
      vel = v0;
    end else if (w.now_time >= t1) begin
      pos = x1;
      vel = v1;
    end else begin
      span = 64'(t1) - 64'(t0);
      tau  = 64'(w.now_time) - 64'(t0);
      s  = (tau << 32) / span;
      s2 = (s * s) >> 32;
      s3 = (s2 * s) >> 32;
      d  = x1 - x0;
      c2 = 3 * d - mul_shift(2 * v0 + v1, span, 16);
      c3 = -2 * d + mul_shift(v0 + v1, span, 16);
      pos = x0 + mul_shift(v0, tau, 16) + mul_shift(c2, s2, 32) + mul_shift(c3, s3, 32);
      n = mul_shift(2 * c2, s, 32) + mul_shift(3 * c3, s2, 32);
      m = (n < 0) ? 64'(-n) : 64'(n);
      q = m / span;
      r = m % span;
      // clamp a huge quotient before scaling; it saturates anyway
      if (q >= (64'd1 << 40)) mag = 64'd1 << 56;
      else mag = (q << 16) + ((r << 16) / span);
      vel = v0 + ((n < 0) ? -longint'(mag) : longint'(mag));
    end
    res.position_out = sat_q16(pos);
    res.velocity_out = sat_q16(vel);
    res.reached_goal = (w.now_time >= t1);
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: hold the word until taken, then advance after a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
      send_gap    <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_axis.push_back(interpolate_axis(in_ch.data, seg_start_q, seg_goal_q));
        words_in <= words_in + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap    <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_words.pop_front();
          send_gap    <= burst_mode ? 0 : $urandom_range(0, 8);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once the stream is running, so the pipe fills
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && words_in >= 200) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each result word against the oldest prediction
  always @(posedge clk) begin
    cti_out_t exp_w;
    int       gap_draw;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_axis.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result word %h", out_ch.data);
        end else begin
          exp_w = expected_axis.pop_front();
          if (exp_w.position_out !== out_ch.data.position_out ||
              exp_w.velocity_out !== out_ch.data.velocity_out ||
              exp_w.reached_goal !== out_ch.data.reached_goal) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected pos %h vel %h reached %b, got pos %h vel %h reached %b",
                       exp_w.position_out, exp_w.velocity_out, exp_w.reached_goal,
                       out_ch.data.position_out, out_ch.data.velocity_out,
                       out_ch.data.reached_goal);
          end
        end
        // a zero gap keeps ready high so words can follow back to back
        gap_draw = burst_mode ? 0 : $urandom_range(0, 8);
        recv_gap <= gap_draw;
        out_ch.ready <= (gap_draw == 0) && (hold_left == 0);
      end else if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[cubic_trajectory_interpolator_top] ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_words.size() != 0 || expected_axis.size() != 0 || in_ch.valid)
      @(posedge clk);
  endtask

  task automatic set_segment(logic [31:0] t0, logic [31:0] t1);
    wait_idle();
    repeat (80) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_TIME;
    cfg_wdata <= t0;
    @(posedge clk);
    cfg_index <= REG_GOAL_TIME;
    cfg_wdata <= t1;
    @(posedge clk);
    cfg_we <= 1'b0;
    seg_start_q = t0;
    seg_goal_q  = t1;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly land inside the segment, where the polynomial is evaluated
  function automatic logic [31:0] pick_time(logic [31:0] t0, logic [31:0] t1);
    if (t1 > t0 + 1 && $urandom_range(0, 9) < 7) return t0 + 1 + $urandom_range(0, t1 - t0 - 2);
    case ($urandom_range(0, 4))
      0: return t0;
      1: return t1;
      2: return 32'hffffffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_word(logic [31:0] t, logic [31:0] x0, logic [31:0] v0,
                            logic [31:0] x1, logic [31:0] v1);
    cti_in_t w;
    w.now_time       = t;
    w.start_position = x0;
    w.start_velocity = v0;
    w.goal_position  = x1;
    w.goal_velocity  = v1;
    pending_words.push_back(w);
  endtask

  task automatic random_phase(logic [31:0] t0, logic [31:0] t1, int count);
    set_segment(t0, t1);
    burst_mode = ($urandom_range(0, 2) == 0);
    for (int i = 0; i < count; i++)
      queue_word(pick_time(t0, t1), pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_START_TIME;
    cfg_wdata   = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    seg_start_q = '0;
    seg_goal_q  = '0;
    burst_mode  = 1'b0;
    mismatches  = 0;
    words_in    = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset segment: both times zero, everything after start is at goal
    queue_word(32'h0, 32'h7fffffff, 32'h80000000, 32'h1, 32'h2);
    queue_word(32'h1, 32'h7fffffff, 32'h80000000, 32'h1, 32'h2);
    queue_word(32'hffffffff, 32'h0, 32'hffffffff, 32'h80000000, 32'h7fffffff);

    // directed: edges of a normal segment and saturating operands
    set_segment(32'h0001_0000, 32'h0005_0000);
    queue_word(32'h0, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    queue_word(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    queue_word(32'h0001_0001, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    queue_word(32'h0003_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000);
    queue_word(32'h0004_ffff, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    queue_word(32'h0005_0000, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    queue_word(32'hffffffff, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0);
    queue_word(32'h0002_0000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    queue_word(32'h0004_0000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    queue_word(32'h0003_8000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);

    // full time range, then goal before start
    set_segment(32'h0, 32'hffffffff);
    queue_word(32'h8000_0000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000);
    queue_word(32'hfffffffe, 32'h0, 32'h7fffffff, 32'h0, 32'h7fffffff);
    queue_word(32'h0000_0001, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
    set_segment(32'hffffffff, 32'h0);
    queue_word(32'hffffffff, 32'h1234_5678, 32'h1, 32'h2, 32'h3);
    queue_word(32'h0, 32'h1234_5678, 32'h1, 32'h2, 32'h3);
    set_segment(32'h0002_0000, 32'h0001_0000);
    queue_word(32'h0001_8000, 32'h1, 32'h2, 32'h3, 32'h4);
    queue_word(32'h0002_0001, 32'h1, 32'h2, 32'h3, 32'h4);
    // shortest interior: a single interior tick between start and goal
    set_segment(32'h0000_0100, 32'h0000_0102);
    queue_word(32'h0000_0101, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);

    random_phase(32'h0, 32'h0004_0000, 160);
    random_phase(32'h0, 32'hffffffff, 140);
    for (int p = 0; p < 7; p++) begin
      a = $urandom;
      b = $urandom;
      case ($urandom_range(0, 3))
        0: random_phase(a, a + $urandom_range(2, 64), 110);
        1: random_phase(a < b ? a : b, a < b ? b : a, 110);
        2: random_phase(a[31:4], a[31:4] + $urandom_range(32'h100, 32'h0010_0000), 110);
        default: random_phase(a, b, 110);
      endcase
    end
    random_phase(32'hffff_0000, 32'hffffffff, 80);

    wait_idle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_axis.size() == 0) begin
      $display("[cubic_trajectory_interpolator_top] OK");
    end else begin
      $display("[cubic_trajectory_interpolator_top] ERROR");
    end
    $finish;
  end

endmodule
